@@ rtl/core/base64url_decoder_macros.svh @@
// Assertion macros for the base64url decoder RTL
`ifndef BASE64URL_DECODER_MACROS_SVH
`define BASE64URL_DECODER_MACROS_SVH

`ifndef SYNTH

// Clocked check, disabled while reset is high
`define B64U_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("base64url decoder check failed");

// Clocked check that also holds during reset
`define B64U_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("base64url decoder check failed");

`else

`define B64U_ASSERT(lbl, clk, rst, prop)
`define B64U_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/core/b64u_pkg.sv @@
// Types and constants for the base64url decoder
`timescale 1ns / 1ps
`default_nettype none

package b64u_pkg;

   localparam int CHAR_W    = 8;
   localparam int SEXTET_W  = 6;
   localparam int TOTAL_W   = 16;
   localparam int CSR_IDX_W = 8;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_62 = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_63 = 8'd1;

   localparam logic [CHAR_W-1:0] SYMBOL_62_RESET = 8'h2D;  // '-'
   localparam logic [CHAR_W-1:0] SYMBOL_63_RESET = 8'h5F;  // '_'

   // Terminators, honored at quad positions 2 and 3 only
   localparam logic [CHAR_W-1:0] CHAR_PAD = 8'h3D;  // '='
   localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

   localparam logic [1:0] POS_0 = 2'd0;
   localparam logic [1:0] POS_1 = 2'd1;
   localparam logic [1:0] POS_2 = 2'd2;
   localparam logic [1:0] POS_3 = 2'd3;

   typedef struct packed {
      logic                hit;
      logic [SEXTET_W-1:0] value;
   } sextet_type;

endpackage

`default_nettype wire

@@ rtl/core/base64url_decoder.sv @@
// Streaming base64url decoder, one character per transfer
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  req     | in        | req_valid/req_ready | req_in_char, req_in_last
//  rsp     | out       | rsp_valid/rsp_ready | rsp_out_byte, rsp_byte_valid,
//          |           |                     | rsp_string_done, rsp_status, rsp_byte_total
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One character per cycle sustained while rsp_ready stays high. rsp_valid rises once the
// req transfer has passed the input register and then the decode into the result register
// and the string state.
// Reset is synchronous, active high; it clears the string state and loads
// symbol_62 = '-' and symbol_63 = '_'. A stalled rsp holds the input register,
// and req_ready drops only when both registers are full and rsp_ready is low.
// csr is always ready.
`timescale 1ns / 1ps
`default_nettype none
`include "base64url_decoder_macros.svh"

module base64url_decoder #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [b64u_pkg::CHAR_W-1:0]       req_in_char,
   input  wire logic                              req_in_last,

   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [b64u_pkg::CHAR_W-1:0]       rsp_out_byte,
   output      logic                              rsp_byte_valid,
   output      logic                              rsp_string_done,
   output      logic                              rsp_status,
   output      logic [b64u_pkg::TOTAL_W-1:0]      rsp_byte_total,

   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [b64u_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [b64u_pkg::CHAR_W-1:0]       csr_data
);
   import b64u_pkg::*;

   localparam int WIDE_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

   // Configuration
   logic [CHAR_W-1:0] sym62_ff, sym62_in;
   logic [CHAR_W-1:0] sym63_ff, sym63_in;

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;

   // String state
   logic [1:0]            quad_ff, quad_in;
   logic [SEXTET_W-1:0]   held_ff, held_in;
   logic                  stopped_ff, stopped_in;
   logic                  failed_ff, failed_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  byte_ff, byte_in;
   logic               bvalid_ff, bvalid_in;
   logic               done_ff, done_in;
   logic               status_ff, status_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic       advance;
   sextet_type sextet;
   logic [COUNT_BITS-1:0] count_next;
   logic [WIDE_W-1:0]     count_wide;

   b64u_sextet u_sextet (
      .char_code (char_ff),
      .symbol_62 (sym62_ff),
      .symbol_63 (sym63_ff),
      .sextet    (sextet)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_comb begin
      sym62_in = sym62_ff;
      sym63_in = sym63_ff;
      if (csr_valid) begin
         if (csr_index == CSR_SYMBOL_62) begin
            sym62_in = csr_data;
         end else if (csr_index == CSR_SYMBOL_63) begin
            sym63_in = csr_data;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      char_in     = char_ff;
      last_in     = last_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         char_in     = req_in_char;
         last_in     = req_in_last;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Decode step
   always_comb begin
      quad_in    = quad_ff;
      held_in    = held_ff;
      stopped_in = stopped_ff;
      failed_in  = failed_ff;
      byte_in    = '0;
      bvalid_in  = 1'b0;
      status_in  = 1'b0;
      count_next = count_ff;

      if (!stopped_ff && !failed_ff) begin
         if ((quad_ff == POS_2 || quad_ff == POS_3) &&
             (char_ff == CHAR_PAD || char_ff == CHAR_NUL)) begin
            stopped_in = 1'b1;
         end else if (!sextet.hit) begin
            failed_in = 1'b1;
         end else begin
            case (quad_ff)
               POS_1: begin
                  byte_in   = {held_ff, sextet.value[5:4]};
                  bvalid_in = 1'b1;
               end
               POS_2: begin
                  byte_in   = {held_ff[3:0], sextet.value[5:2]};
                  bvalid_in = 1'b1;
               end
               POS_3: begin
                  byte_in   = {held_ff[1:0], sextet.value};
                  bvalid_in = 1'b1;
               end
               default: begin
                  bvalid_in = 1'b0;
               end
            endcase
            held_in = sextet.value;
            quad_in = quad_ff + 2'd1;
            if (bvalid_in && !(&count_ff)) begin
               count_next = count_ff + COUNT_BITS'(1);
            end
         end
      end

      count_wide = WIDE_W'(count_next);
      total_in   = (count_wide > WIDE_W'({TOTAL_W{1'b1}})) ?
                   {TOTAL_W{1'b1}} : count_wide[TOTAL_W-1:0];
      count_in   = count_next;
      done_in    = last_ff;

      if (last_ff) begin
         // a lone sextet at the end of the string is an error
         status_in  = failed_in || (!stopped_in && quad_in == POS_1);
         quad_in    = POS_0;
         held_in    = '0;
         stopped_in = 1'b0;
         failed_in  = 1'b0;
         count_in   = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym62_ff     <= SYMBOL_62_RESET;
         sym63_ff     <= SYMBOL_63_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         quad_ff      <= POS_0;
         held_ff      <= '0;
         stopped_ff   <= 1'b0;
         failed_ff    <= 1'b0;
         count_ff     <= '0;
      end else begin
         sym62_ff     <= sym62_in;
         sym63_ff     <= sym63_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            quad_ff    <= quad_in;
            held_ff    <= held_in;
            stopped_ff <= stopped_in;
            failed_ff  <= failed_in;
            count_ff   <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      if (advance) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         done_ff   <= done_in;
         status_ff <= status_in;
         total_ff  <= total_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_string_done = done_ff;
   assign rsp_status      = status_ff;
   assign rsp_byte_total  = total_ff;

   `B64U_ASSERT(a_status_only_at_done, clock, reset,
      rsp_valid && rsp_status |-> rsp_string_done)
   `B64U_ASSERT(a_byte_counted, clock, reset,
      rsp_valid && rsp_byte_valid |-> rsp_byte_total != '0)
   `B64U_ASSERT(a_idle_byte_zero, clock, reset,
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == '0)
   `B64U_ASSERT(a_clear_after_last, clock, reset,
      advance && last_ff |=> quad_ff == POS_0 && !stopped_ff && !failed_ff
                             && count_ff == '0)
   `B64U_ASSERT(a_stop_fail_exclusive, clock, reset,
      !(stopped_ff && failed_ff))
   `B64U_ASSERT_ALWAYS(a_reset_empties, clock,
      reset |=> !rsp_valid && !in_valid_ff)

endmodule

`default_nettype wire

@@ rtl/core/b64u_sextet.sv @@
// Character to six-bit value lookup for the URL-safe alphabet
`timescale 1ns / 1ps
`default_nettype none

module b64u_sextet (
   input  wire logic [b64u_pkg::CHAR_W-1:0] char_code,
   input  wire logic [b64u_pkg::CHAR_W-1:0] symbol_62,
   input  wire logic [b64u_pkg::CHAR_W-1:0] symbol_63,
   output b64u_pkg::sextet_type             sextet
);
   import b64u_pkg::*;

   // Letters and digits win over the registers, symbol_62 over symbol_63
   always_comb begin
      sextet.hit   = 1'b1;
      sextet.value = '0;
      if (char_code inside {[8'h41:8'h5A]}) begin
         sextet.value = SEXTET_W'(char_code - 8'h41);
      end else if (char_code inside {[8'h61:8'h7A]}) begin
         sextet.value = SEXTET_W'(char_code - 8'h47);
      end else if (char_code inside {[8'h30:8'h39]}) begin
         sextet.value = SEXTET_W'(char_code + 8'h04);
      end else if (char_code == symbol_62) begin
         sextet.value = 6'd62;
      end else if (char_code == symbol_63) begin
         sextet.value = 6'd63;
      end else begin
         sextet.hit = 1'b0;
      end
   end

endmodule

`default_nettype wire
